// ===== src/sfms_pkg.sv =====
// Package for the substring first-match search core.
// Holds payload structs, action and status codes, and default sizes; no dependencies.
package sfms_pkg;

    localparam int SFMS_PATTERN_MAX = 32;
    localparam int SFMS_TEXT_MAX    = 65536;
    localparam int POS_W            = 17;

    localparam logic [1:0] ACT_PATTERN = 2'd0;
    localparam logic [1:0] ACT_TEXT    = 2'd1;
    localparam logic [1:0] ACT_REPORT  = 2'd2;

    localparam logic [1:0] STAT_FOUND     = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_PAT_LONG  = 2'd2;
    localparam logic [1:0] STAT_TEXT_LONG = 2'd3;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] match_position;
    } out_item_t;

    // Per-cycle commands from the controller to every cell of the row.
    typedef struct packed {
        logic pat_shift;
        logic txt_shift;
        logic clear;
    } cell_ctl_t;

endpackage

// ===== src/sfms_cell.sv =====
// One cell of the search row: a pattern byte, its active flag and a window byte.
// Depends on sfms_pkg for the cell command struct.
module sfms_cell
    import sfms_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  logic [7:0] pat_in,
    input  logic       act_in,
    input  logic [7:0] win_in,
    output logic [7:0] pat_out,
    output logic       act_out,
    output logic [7:0] win_out,
    output logic       ok
);

    logic [7:0] pat_reg;
    logic [7:0] pat_next;
    logic [7:0] win_reg;
    logic [7:0] win_next;
    logic       act_reg;
    logic       act_next;

    always_comb
    begin
        pat_next = ctl.pat_shift ? pat_in : pat_reg;
        win_next = ctl.txt_shift ? win_in : win_reg;
        if (ctl.clear)
        begin
            act_next = 1'b0;
        end
        else if (ctl.pat_shift)
        begin
            act_next = act_in;
        end
        else
        begin
            act_next = act_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
        win_reg <= win_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else
        begin
            act_reg <= act_next;
        end
    end

    // The compare looks at the window byte this cell will hold after the shift.
    assign ok      = !act_reg || (win_in == pat_reg);
    assign pat_out = pat_reg;
    assign act_out = act_reg;
    assign win_out = win_reg;

endmodule

// ===== src/sfms_ctrl.sv =====
// Controller of the search: counters, flags, start offset, result register.
// Depends on sfms_pkg; drives the cell row commands and the output beat.
module sfms_ctrl
    import sfms_pkg::*;
#(
    parameter int PATTERN_MAX = SFMS_PATTERN_MAX,
    parameter int TEXT_MAX    = SFMS_TEXT_MAX
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_item,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [POS_W-1:0] cfg_data,
    input  logic             row_ok,
    output cell_ctl_t        ctl
);

    localparam int PCW = $clog2(PATTERN_MAX + 1);
    localparam int TCW = $clog2(TEXT_MAX + 1);
    localparam int CW  = (TCW > POS_W) ? TCW : POS_W;

    logic [PCW-1:0]   pcount_reg, pcount_next;
    logic             pat_ovf_reg, pat_ovf_next;
    logic [TCW-1:0]   tcount_reg, tcount_next;
    logic             txt_ovf_reg, txt_ovf_next;
    logic             seen_reg, seen_next;
    logic [POS_W-1:0] first_reg, first_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_item_reg, out_item_next;

    logic           fire;
    logic           pat_take;
    logic           txt_take;
    logic           report;
    logic [TCW-1:0] tc_inc;
    logic [CW-1:0]  tc_ext;
    logic [CW-1:0]  pc_ext;
    logic [CW-1:0]  so_ext;
    logic [CW-1:0]  begin_pos;
    logic           hit;
    out_item_t      result;

    assign in_ready  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign fire      = in_valid && in_ready;

    assign pat_take = fire && (in_item.action == ACT_PATTERN)
                      && (tcount_reg == '0) && !txt_ovf_reg;
    assign txt_take = fire && (in_item.action == ACT_TEXT)
                      && (tcount_reg != TCW'(TEXT_MAX));
    assign report   = fire && (in_item.action == ACT_REPORT);

    assign tc_inc    = tcount_reg + 1'b1;
    assign tc_ext    = CW'(tc_inc);
    assign pc_ext    = CW'(pcount_reg);
    assign so_ext    = CW'(start_reg);
    assign begin_pos = tc_ext - pc_ext;

    assign hit = txt_take && !seen_reg && !pat_ovf_reg && (pcount_reg != '0)
                 && (tc_ext >= pc_ext) && (begin_pos >= so_ext) && row_ok;

    always_comb
    begin
        result.status         = STAT_NOT_FOUND;
        result.match_position = '0;
        if (pat_ovf_reg)
        begin
            result.status = STAT_PAT_LONG;
        end
        else if (txt_ovf_reg)
        begin
            result.status = STAT_TEXT_LONG;
        end
        else if (pcount_reg == '0)
        begin
            // An empty pattern matches at the start offset if it lies within the text.
            if (so_ext <= CW'(tcount_reg))
            begin
                result.status         = STAT_FOUND;
                result.match_position = start_reg;
            end
        end
        else if (seen_reg)
        begin
            result.status         = STAT_FOUND;
            result.match_position = first_reg;
        end
    end

    always_comb
    begin
        ctl.pat_shift = pat_take && (pcount_reg != PCW'(PATTERN_MAX));
        ctl.txt_shift = txt_take;
        ctl.clear     = report;

        pcount_next = pcount_reg;
        pat_ovf_next = pat_ovf_reg;
        tcount_next = tcount_reg;
        txt_ovf_next = txt_ovf_reg;
        seen_next   = seen_reg;
        first_next  = first_reg;
        start_next  = cfg_valid ? cfg_data : start_reg;

        if (pat_take)
        begin
            if (pcount_reg != PCW'(PATTERN_MAX))
            begin
                pcount_next = pcount_reg + 1'b1;
            end
            else
            begin
                pat_ovf_next = 1'b1;
            end
        end
        if (fire && (in_item.action == ACT_TEXT) && !txt_take)
        begin
            txt_ovf_next = 1'b1;
        end
        if (txt_take)
        begin
            tcount_next = tc_inc;
        end
        if (hit)
        begin
            seen_next  = 1'b1;
            first_next = begin_pos[POS_W-1:0];
        end
        if (report)
        begin
            pcount_next  = '0;
            pat_ovf_next = 1'b0;
            tcount_next  = '0;
            txt_ovf_next = 1'b0;
            seen_next    = 1'b0;
            first_next   = '0;
        end

        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg;
        if (report)
        begin
            out_valid_next = 1'b1;
            out_item_next  = result;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg    <= '0;
            pat_ovf_reg   <= 1'b0;
            tcount_reg    <= '0;
            txt_ovf_reg   <= 1'b0;
            seen_reg      <= 1'b0;
            first_reg     <= '0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pcount_reg    <= pcount_next;
            pat_ovf_reg   <= pat_ovf_next;
            tcount_reg    <= tcount_next;
            txt_ovf_reg   <= txt_ovf_next;
            seen_reg      <= seen_next;
            first_reg     <= first_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== src/substring_first_match_search_core.sv =====
// Top level of the substring first-match search core.
// Depends on sfms_pkg, sfms_cell and sfms_ctrl.
//
// The core takes one input beat every clock cycle: pattern bytes, text bytes and
// end-of-text beats alike, with no gap between them. The pattern and the last
// PATTERN_MAX text bytes live in a row of PATTERN_MAX cells; each text beat shifts
// the window one cell and all cells compare in the same cycle, so the full-row
// compare and AND reduce set the cycle time. The result of an end-of-text beat is
// offered on the output in the cycle after that beat. While a result is held and the
// output is not ready, the input stalls for every kind of beat; in a cycle where the
// output is ready, the next beat is taken with no gap.
module substring_first_match_search_core
    import sfms_pkg::*;
#(
    parameter int PATTERN_MAX = SFMS_PATTERN_MAX,
    parameter int TEXT_MAX    = SFMS_TEXT_MAX
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_item,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [POS_W-1:0] cfg_data
);

    cell_ctl_t                  ctl;
    logic [PATTERN_MAX:0][7:0]  pat_chain;
    logic [PATTERN_MAX:0]       act_chain;
    logic [PATTERN_MAX:0][7:0]  win_chain;
    logic [PATTERN_MAX-1:0]     ok_vec;

    // New bytes enter at cell 0; cell j then holds pattern byte count-1-j,
    // which lines up with window byte j.
    assign pat_chain[0] = in_item.data_byte;
    assign act_chain[0] = 1'b1;
    assign win_chain[0] = in_item.data_byte;

    for (genvar j = 0; j < PATTERN_MAX; j++)
    begin : g_cell
        sfms_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .pat_in  (pat_chain[j]),
            .act_in  (act_chain[j]),
            .win_in  (win_chain[j]),
            .pat_out (pat_chain[j+1]),
            .act_out (act_chain[j+1]),
            .win_out (win_chain[j+1]),
            .ok      (ok_vec[j])
        );
    end

    sfms_ctrl #(
        .PATTERN_MAX (PATTERN_MAX),
        .TEXT_MAX    (TEXT_MAX)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .row_ok    (&ok_vec),
        .ctl       (ctl)
    );

endmodule

// ===== src/sfms_checker.sv =====
// Port-level checks for the substring first-match search core, bound to the top.
// Depends on sfms_pkg for payload types and codes.
module sfms_checker
    import sfms_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_item,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    // A held result must not change until its beat is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("output beat changed while stalled");

    // Every end-of-text beat shows a result on the next cycle.
    a_report_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_item.action == ACT_REPORT) |=> out_valid)
        else $error("no result after end-of-text beat");

    // The position is zero for every status other than found.
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status != STAT_FOUND) |-> out_item.match_position == '0)
        else $error("nonzero position without a match");

    // With a result still held, the input side must stall.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result held");

endmodule

bind substring_first_match_search_core sfms_checker u_sfms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
